FILE: rtl/ptc_pkg.sv
// Package for the pulse train capture table.
// Holds the payload widths, the operation codes, the controller states and the
// command bundle. It depends on nothing.
`default_nettype none

package ptc_pkg;

	// Fixed payload field widths.
	localparam int OP_W  = 2;
	localparam int TS_W  = 32;
	localparam int DUR_W = 16;
	localparam int RI_W  = 3;
	localparam int BI_W  = 6;
	localparam int LEN_W = 7;

	// Operation codes; the unused code is a no-op.
	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 2'd0,
		OP_READ   = 2'd1,
		OP_FLUSH  = 2'd2
	} op_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic exec;
		logic finish;
		logic load_out;
	} cmd_t;

endpackage

`default_nettype wire

FILE: rtl/ptc_if.sv
// Handshake channels of the pulse train capture table: requests in, results out.
// Depends on ptc_pkg for the field widths.
`default_nettype none

interface ptc_item_if;
	import ptc_pkg::*;

	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    op;
	logic               pin_level;
	logic               new_row;
	logic [TS_W-1:0]    time_stamp;
	logic [RI_W-1:0]    row_index;
	logic [BI_W-1:0]    bit_index;

	modport source (
		output valid, op, pin_level, new_row, time_stamp, row_index, bit_index,
		input  ready
	);
	modport sink (
		input  valid, op, pin_level, new_row, time_stamp, row_index, bit_index,
		output ready
	);
endinterface

interface ptc_result_if;
	import ptc_pkg::*;

	logic               valid;
	logic               ready;
	logic               accepted;
	logic               level;
	logic [DUR_W-1:0]   duration;
	logic [LEN_W-1:0]   row_length;
	logic               row_overflow;
	logic               row_valid;

	modport source (
		output valid, accepted, level, duration, row_length, row_overflow, row_valid,
		input  ready
	);
	modport sink (
		input  valid, accepted, level, duration, row_length, row_overflow, row_valid,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/ptc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the entry level and entry duration stores; no dependencies.
`default_nettype none

module ptc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [$clog2(DEPTH)-1:0]  waddr,
	input  wire logic [WIDTH-1:0]          wdata,
	input  wire logic [$clog2(DEPTH)-1:0]  raddr,
	output logic      [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write first in program order, read data registered.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/ptc_ctrl.sv
// Controller of the pulse train capture table: request handshake, sequencing
// and the result valid flag. Depends on ptc_pkg.
`default_nettype none

module ptc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output ptc_pkg::cmd_t      cmd
);
	import ptc_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	// The result register can take a new value when empty or being drained.
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				if (out_free) begin
					cmd.load_out = 1'b1;
					in_ready     = 1'b1;
					if (in_valid) begin
						cmd.capture = 1'b1;
						state_d     = ST_EXEC;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/ptc_datapath.sv
// Datapath of the pulse train capture table: row bookkeeping, duration
// arithmetic, the two entry RAMs and the result register.
// Depends on ptc_pkg and ptc_ram.
`default_nettype none

module ptc_datapath #(
	parameter int ROWS            = 8,
	parameter int ENTRIES_PER_ROW = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire ptc_pkg::cmd_t               cmd,
	input  wire logic [ptc_pkg::OP_W-1:0]    op,
	input  wire logic                        pin_level,
	input  wire logic                        new_row,
	input  wire logic [ptc_pkg::TS_W-1:0]    time_stamp,
	input  wire logic [ptc_pkg::RI_W-1:0]    row_index,
	input  wire logic [ptc_pkg::BI_W-1:0]    bit_index,
	output logic                             accepted,
	output logic                             level,
	output logic      [ptc_pkg::DUR_W-1:0]   duration,
	output logic      [ptc_pkg::LEN_W-1:0]   row_length,
	output logic                             row_overflow,
	output logic                             row_valid
);
	import ptc_pkg::*;

	localparam int ROW_W  = $clog2(ROWS);
	localparam int CNT_W  = $clog2(ENTRIES_PER_ROW + 1);
	localparam int IDX_W  = $clog2(ENTRIES_PER_ROW);
	localparam int DEPTH  = ROWS * ENTRIES_PER_ROW;
	localparam int ADDR_W = $clog2(DEPTH);

	// Captured request.
	logic [OP_W-1:0]  op_q;
	logic             pin_level_q;
	logic             new_row_q;
	logic [DUR_W-1:0] ts_q;
	logic [RI_W-1:0]  row_index_q;
	logic [BI_W-1:0]  bit_index_q;

	// Row state. Only the low duration bits of times matter for the result.
	logic [CNT_W-1:0] row_count_q [ROWS];
	logic             row_spill_q [ROWS];
	logic [DUR_W-1:0] row_start_q [ROWS];
	logic [ROW_W-1:0] cur_q;
	logic [DUR_W-1:0] sum_q;

	// Deferred zero write of a new entry's duration.
	logic              wr0_q;
	logic [ADDR_W-1:0] wr0_addr_q;

	// Per-request status captured during execution.
	logic             acc_q;
	logic             hit_q;
	logic             rvalid_q;
	logic             ovf_q;
	logic [CNT_W-1:0] len_q;

	// Result register.
	logic             accepted_q;
	logic             level_q;
	logic [DUR_W-1:0] duration_q;
	logic [LEN_W-1:0] row_length_q;
	logic             row_overflow_q;
	logic             row_valid_q;

	logic              is_append;
	logic              is_read;
	logic [ROW_W-1:0]  rd_row;
	logic [ROW_W-1:0]  sel_row;
	logic [CNT_W-1:0]  cnt_sel;
	logic [DUR_W-1:0]  start_cur;
	logic [ROW_W:0]    cur_inc;
	logic              next_ok;
	logic [DUR_W-1:0]  dur_close;
	logic              ap_ok;
	logic              ap_close;
	logic              set_start;
	logic              set_spill;
	logic [ROW_W-1:0]  ap_row;
	logic [IDX_W-1:0]  ap_k;
	logic [IDX_W-1:0]  close_idx;
	logic [DUR_W-1:0]  sum_nxt;
	logic [ADDR_W-1:0] new_addr;
	logic [ADDR_W-1:0] close_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic              rd_row_ok;
	logic              rd_hit;
	logic              lvl_we;
	logic              dur_we;
	logic [ADDR_W-1:0] dur_waddr;
	logic [DUR_W-1:0]  dur_wdata;
	logic              lvl_rdata;
	logic [DUR_W-1:0]  dur_rdata;

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q        <= op;
			pin_level_q <= pin_level;
			new_row_q   <= new_row;
			ts_q        <= time_stamp[DUR_W-1:0];
			row_index_q <= row_index;
			bit_index_q <= bit_index;
		end
	end

	assign is_append = (op_q == OP_APPEND);
	assign is_read   = (op_q == OP_READ);

	// One row count read port, shared by append and read.
	assign rd_row    = ROW_W'(row_index_q);
	assign sel_row   = is_read ? rd_row : cur_q;
	assign cnt_sel   = row_count_q[sel_row];
	assign start_cur = row_start_q[cur_q];
	assign cur_inc   = {1'b0, cur_q} + (ROW_W + 1)'(1);
	assign next_ok   = int'(cur_inc) < ROWS;

	// Duration of the entry being closed; it always lies in the current row.
	assign dur_close = ts_q - start_cur - sum_q;

	// Append planning.
	always_comb begin
		ap_ok     = 1'b0;
		ap_close  = 1'b0;
		set_start = 1'b0;
		set_spill = 1'b0;
		ap_row    = cur_q;
		ap_k      = '0;
		close_idx = '0;
		sum_nxt   = sum_q;
		if (new_row_q) begin
			if (cnt_sel != '0) begin
				// Open the next row, if there is one.
				ap_ok     = next_ok;
				ap_row    = cur_inc[ROW_W-1:0];
				set_start = 1'b1;
				sum_nxt   = '0;
			end else begin
				// Empty current row: stay on it and reload its start time.
				ap_ok     = 1'b1;
				set_start = 1'b1;
			end
		end else if (cnt_sel == CNT_W'(ENTRIES_PER_ROW)) begin
			// Full row: mark the spill; if there is a next row, close its last entry and move on.
			set_spill = 1'b1;
			ap_ok     = next_ok;
			ap_close  = next_ok;
			close_idx = IDX_W'(ENTRIES_PER_ROW - 1);
			ap_row    = cur_inc[ROW_W-1:0];
			set_start = 1'b1;
			sum_nxt   = '0;
		end else begin
			ap_ok = 1'b1;
			ap_k  = cnt_sel[IDX_W-1:0];
			if (cnt_sel != '0) begin
				ap_close  = 1'b1;
				close_idx = IDX_W'(cnt_sel - CNT_W'(1));
				sum_nxt   = sum_q + dur_close;
			end
		end
	end

	assign new_addr   = ADDR_W'(int'(ap_row) * ENTRIES_PER_ROW + int'(ap_k));
	assign close_addr = ADDR_W'(int'(cur_q) * ENTRIES_PER_ROW + int'(close_idx));

	// Read lookup.
	assign rd_row_ok = (int'(row_index_q) < ROWS) && (int'(row_index_q) <= int'(cur_q));
	assign rd_hit    = rd_row_ok && (int'(bit_index_q) < int'(cnt_sel))
		&& (int'(bit_index_q) < ENTRIES_PER_ROW);
	assign rd_addr   = ADDR_W'(int'(row_index_q) * ENTRIES_PER_ROW + int'(bit_index_q));

	// Row bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROWS; i++) begin
				row_count_q[i] <= '0;
				row_spill_q[i] <= 1'b0;
			end
			cur_q <= '0;
			sum_q <= '0;
		end else if (cmd.exec) begin
			case (op_q)
				OP_APPEND: begin
					if (set_spill) begin
						row_spill_q[cur_q] <= 1'b1;
					end
					if (ap_ok) begin
						row_count_q[ap_row] <= CNT_W'(ap_k) + CNT_W'(1);
						cur_q               <= ap_row;
						sum_q               <= sum_nxt;
					end
				end
				OP_FLUSH: begin
					for (int i = 0; i < ROWS; i++) begin
						row_count_q[i] <= '0;
						row_spill_q[i] <= 1'b0;
					end
					cur_q <= '0;
					sum_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Row start times have no reset value.
	always_ff @(posedge clk) begin
		if (cmd.exec && is_append && ap_ok && set_start) begin
			row_start_q[ap_row] <= ts_q;
		end
	end

	// Execution status and the deferred zero write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr0_q    <= 1'b0;
			acc_q    <= 1'b0;
			hit_q    <= 1'b0;
			rvalid_q <= 1'b0;
			ovf_q    <= 1'b0;
			len_q    <= '0;
		end else if (cmd.exec) begin
			wr0_q    <= is_append && ap_ok;
			acc_q    <= is_append && ap_ok;
			hit_q    <= is_read && rd_hit;
			rvalid_q <= is_read && rd_row_ok;
			ovf_q    <= is_read && rd_row_ok && row_spill_q[rd_row];
			len_q    <= (is_read && rd_row_ok) ? cnt_sel : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			wr0_addr_q <= new_addr;
		end
	end

	// RAM write ports: level once, duration close then the new entry's zero.
	assign lvl_we    = cmd.exec && is_append && ap_ok;
	assign dur_we    = (cmd.exec && is_append && ap_close) || (cmd.finish && wr0_q);
	assign dur_waddr = cmd.finish ? wr0_addr_q : close_addr;
	assign dur_wdata = cmd.finish ? '0 : dur_close;

	ptc_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_level_ram (
		.clk   (clk),
		.we    (lvl_we),
		.waddr (new_addr),
		.wdata (pin_level_q),
		.raddr (rd_addr),
		.rdata (lvl_rdata)
	);

	ptc_ram #(
		.WIDTH (DUR_W),
		.DEPTH (DEPTH)
	) u_duration_ram (
		.clk   (clk),
		.we    (dur_we),
		.waddr (dur_waddr),
		.wdata (dur_wdata),
		.raddr (rd_addr),
		.rdata (dur_rdata)
	);

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			accepted_q     <= acc_q;
			level_q        <= hit_q ? lvl_rdata : 1'b0;
			duration_q     <= hit_q ? dur_rdata : '0;
			row_length_q   <= LEN_W'(len_q);
			row_overflow_q <= ovf_q;
			row_valid_q    <= rvalid_q;
		end
	end

	assign accepted     = accepted_q;
	assign level        = level_q;
	assign duration     = duration_q;
	assign row_length   = row_length_q;
	assign row_overflow = row_overflow_q;
	assign row_valid    = row_valid_q;

endmodule

`default_nettype wire

FILE: rtl/pulse_train_capture_table_core.sv
// Top level of the pulse train capture table.
// Depends on ptc_pkg, ptc_if, ptc_ctrl, ptc_datapath and ptc_ram.
//
//  Channel  Dir  Handshake      Payload
//  item     in   valid/ready    op, pin_level, new_row, time_stamp, row_index, bit_index
//  result   out  valid/ready    accepted, level, duration, row_length, row_overflow, row_valid
//
// Each request passes through an execute state that updates the row state and
// does the first entry RAM write or the RAM read, and a finish state for the
// second duration write or the registered read data, in which the next request
// can be accepted once the result register is free.
// Reset clears the row counts, spill marks and current row at once; the entry
// RAMs are not cleared. A stalled result is held in the output register; one
// more request is accepted and executed meanwhile, then waits for the slot.
`default_nettype none

module pulse_train_capture_table_core #(
	parameter int ROWS            = 8,
	parameter int ENTRIES_PER_ROW = 64
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	ptc_item_if.sink      item,
	ptc_result_if.source  result
);
	import ptc_pkg::*;

	cmd_t cmd;

	ptc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	ptc_datapath #(
		.ROWS            (ROWS),
		.ENTRIES_PER_ROW (ENTRIES_PER_ROW)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.op           (item.op),
		.pin_level    (item.pin_level),
		.new_row      (item.new_row),
		.time_stamp   (item.time_stamp),
		.row_index    (item.row_index),
		.bit_index    (item.bit_index),
		.accepted     (result.accepted),
		.level        (result.level),
		.duration     (result.duration),
		.row_length   (result.row_length),
		.row_overflow (result.row_overflow),
		.row_valid    (result.row_valid)
	);

endmodule

`default_nettype wire

FILE: test/pulse_train_capture_table_core_test.sv
// Self-checking testbench for the pulse train capture table core.
// Depends on ptc_pkg, the ptc_if channel interfaces and the core itself.
// A scoreboard class predicts every result; plain tasks drive the requests.
`timescale 1ns / 100ps

import ptc_pkg::*;

localparam int TABLE_ROWS  = 8;
localparam int ROW_ENTRIES = 64;

// The op code that the block treats as a no-op.
localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

typedef struct packed {
	logic [OP_W-1:0] op;
	logic            pin_level;
	logic            new_row;
	logic [TS_W-1:0] time_stamp;
	logic [RI_W-1:0] row_index;
	logic [BI_W-1:0] bit_index;
} capture_request_t;

typedef struct packed {
	logic             accepted;
	logic             level;
	logic [DUR_W-1:0] duration;
	logic [LEN_W-1:0] row_length;
	logic             row_overflow;
	logic             row_valid;
} capture_result_t;

// Keeps a shadow of the capture table and the results still owed by the core.
class capture_table_scoreboard;
	bit               lvl_mem [TABLE_ROWS*ROW_ENTRIES];
	bit [DUR_W-1:0]   dur_mem [TABLE_ROWS*ROW_ENTRIES];
	bit [TS_W-1:0]    row_start [TABLE_ROWS];
	bit               start_known [TABLE_ROWS];
	bit [LEN_W-1:0]   row_len [TABLE_ROWS];
	bit               row_spill [TABLE_ROWS];
	int               cur_row;
	bit [TS_W-1:0]    run_sum;
	capture_result_t  pending_results [$];
	int               errors;

	function new();
		foreach (start_known[i]) start_known[i] = 0;
		clear_rows();
		errors = 0;
	endfunction

	function void clear_rows();
		foreach (row_len[i]) begin
			row_len[i]   = 0;
			row_spill[i] = 0;
		end
		cur_row = 0;
		run_sum = 0;
	endfunction

	// Closes one entry at time ts and adds its duration to the row sum.
	function void close_entry(int r, int pos, bit [TS_W-1:0] ts);
		bit [TS_W-1:0] diff;
		diff = ts - row_start[r] - run_sum;
		dur_mem[r*ROW_ENTRIES + pos] = diff[DUR_W-1:0];
		run_sum += {16'b0, diff[DUR_W-1:0]};
	endfunction

	function bit append_edge(bit lvl, bit fresh, bit [TS_W-1:0] ts);
		int r;
		int k;
		r = cur_row;
		if (fresh) begin
			if (row_len[r] != 0) begin
				r++;
				if (r >= TABLE_ROWS)
					return 0;
				run_sum = 0;
			end
			row_start[r]   = ts;
			start_known[r] = 1;
		end
		// A full row spills into the next one, unless it is the last row.
		if (row_len[r] >= ROW_ENTRIES) begin
			row_spill[r] = 1;
			if (r + 1 >= TABLE_ROWS)
				return 0;
			close_entry(r, int'(row_len[r]) - 1, ts);
			r++;
			row_start[r]   = ts;
			start_known[r] = 1;
			run_sum        = 0;
		end
		k = row_len[r];
		lvl_mem[r*ROW_ENTRIES + k] = lvl;
		dur_mem[r*ROW_ENTRIES + k] = 0;
		if (k != 0)
			close_entry(r, k - 1, ts);
		row_len[r] = LEN_W'(k + 1);
		cur_row    = r;
		return 1;
	endfunction

	function capture_result_t predict_table_step(capture_request_t rq);
		capture_result_t rs;
		int ri;
		rs = '0;
		ri = rq.row_index;
		case (rq.op)
			OP_APPEND: rs.accepted = append_edge(rq.pin_level, rq.new_row, rq.time_stamp);
			OP_READ: begin
				if (ri <= cur_row) begin
					if (rq.bit_index < row_len[ri]) begin
						rs.level    = lvl_mem[ri*ROW_ENTRIES + rq.bit_index];
						rs.duration = dur_mem[ri*ROW_ENTRIES + rq.bit_index];
					end
					rs.row_length   = row_len[ri];
					rs.row_overflow = row_spill[ri];
					rs.row_valid    = 1;
				end
			end
			OP_FLUSH: clear_rows();
			default: ;
		endcase
		return rs;
	endfunction

	function void note_request(capture_request_t rq);
		pending_results.push_back(predict_table_step(rq));
	endfunction

	task report(string msg);
		errors++;
		$display("ERROR at %0t: %s", $time, msg);
	endtask

	task check_result(capture_result_t got);
		capture_result_t want;
		string diffs;
		if (pending_results.size() == 0) begin
			report($sformatf("result with no request waiting: %p", got));
			return;
		end
		want  = pending_results.pop_front();
		diffs = "";
		if (got.accepted !== want.accepted)
			diffs = {diffs, $sformatf(" accepted %0h/%0h", got.accepted, want.accepted)};
		if (got.level !== want.level)
			diffs = {diffs, $sformatf(" level %0h/%0h", got.level, want.level)};
		if (got.duration !== want.duration)
			diffs = {diffs, $sformatf(" duration %0h/%0h", got.duration, want.duration)};
		if (got.row_length !== want.row_length)
			diffs = {diffs, $sformatf(" row_length %0d/%0d", got.row_length, want.row_length)};
		if (got.row_overflow !== want.row_overflow)
			diffs = {diffs, $sformatf(" row_overflow %0h/%0h", got.row_overflow,
				want.row_overflow)};
		if (got.row_valid !== want.row_valid)
			diffs = {diffs, $sformatf(" row_valid %0h/%0h", got.row_valid, want.row_valid)};
		if (diffs != "")
			report({"result mismatch (got/expected):", diffs});
	endtask
endclass

module pulse_train_capture_table_core_test;

	localparam int IDLE_LIMIT     = 2000;
	localparam int RANDOM_ITEMS   = 700;
	localparam int DRAIN_CYCLES   = 10;

	logic clk;
	logic arst_n;
	bit   quiet;
	bit [TS_W-1:0] edge_clock;
	int   idle_cycles;

	capture_table_scoreboard capture_sb;

	ptc_item_if   item_ch ();
	ptc_result_if result_ch ();

	pulse_train_capture_table_core #(
		.ROWS(TABLE_ROWS),
		.ENTRIES_PER_ROW(ROW_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	// Send one request; entered and left at a falling edge.
	task send_request(capture_request_t rq);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			item_ch.valid = 0;
			repeat (gap) @(negedge clk);
		end
		item_ch.op         = rq.op;
		item_ch.pin_level  = rq.pin_level;
		item_ch.new_row    = rq.new_row;
		item_ch.time_stamp = rq.time_stamp;
		item_ch.row_index  = rq.row_index;
		item_ch.bit_index  = rq.bit_index;
		item_ch.valid      = 1;
		do @(posedge clk); while (!item_ch.ready);
		capture_sb.note_request(rq);
		@(negedge clk);
	endtask

	// Other fields of every request carry random noise.
	function capture_request_t noise_request(logic [OP_W-1:0] op);
		capture_request_t rq;
		rq            = capture_request_t'({$urandom(), $urandom()});
		rq.time_stamp = $urandom();
		rq.op         = op;
		return rq;
	endfunction

	task send_append(bit lvl, bit fresh, bit [TS_W-1:0] ts);
		capture_request_t rq;
		rq            = noise_request(OP_APPEND);
		rq.pin_level  = lvl;
		rq.new_row    = fresh;
		rq.time_stamp = ts;
		send_request(rq);
	endtask

	task send_read(int ri, int bi);
		capture_request_t rq;
		rq           = noise_request(OP_READ);
		rq.row_index = RI_W'(ri);
		rq.bit_index = BI_W'(bi);
		send_request(rq);
	endtask

	task send_flush();
		send_request(noise_request(OP_FLUSH));
	endtask

	// Edge times mostly creep forward, sometimes jump far or anywhere.
	function bit [TS_W-1:0] next_edge_time();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 90)
			edge_clock += $urandom_range(0, 3000);
		else if (pick < 98)
			edge_clock += $urandom_range(0, 32'h00FF_FFFF);
		else
			edge_clock = $urandom();
		return edge_clock;
	endfunction

	task run_directed();
		capture_request_t rq;
		// Reads on the empty table: row 0 is valid, a row beyond it is not.
		send_read(0, 0);
		send_read(7, 63);
		rq = '1;
		send_request(rq);
		send_flush();
		// New row on the empty row reloads its start; the times wrap around.
		send_append(1, 1, 32'hFFFF_FFF0);
		send_append(0, 0, 32'h0000_0010);
		send_append(1, 0, 32'h0001_0030);
		send_append(0, 0, 32'h0001_0030);
		send_append(1, 1, 32'h8000_0000);
		send_append(0, 1, 32'h8000_FFFF);
		send_read(0, 0);
		send_read(0, 1);
		send_read(0, 2);
		send_read(0, 3);
		send_read(0, 63);
		send_read(1, 0);
		send_read(2, 0);
		send_read(3, 0);
		// After a flush the start time of row 0 is still in place.
		send_flush();
		send_read(0, 0);
		send_append(1, 0, 32'h0000_1000);
		send_append(0, 1, 32'h0000_2000);
		send_read(1, 0);
	endtask

	// Sessions start from a flushed table and differ in how often rows change:
	// many short rows, a jump to the last row and filling it, or long rows
	// that fill and spill.
	task run_random();
		int sent;
		int kind;
		int length;
		int pick;
		int ri;
		int bi;
		bit fresh;
		sent       = 0;
		edge_clock = $urandom();
		while (sent < RANDOM_ITEMS) begin
			kind   = $urandom_range(0, 2);
			quiet  = ($urandom_range(0, 3) == 0);
			length = $urandom_range(60, 160);
			send_flush();
			sent++;
			repeat (length) begin
				if (sent >= RANDOM_ITEMS)
					break;
				pick = $urandom_range(0, 99);
				if (pick < 2) begin
					send_request(noise_request(OP_UNUSED));
				end else if (pick < 3) begin
					send_flush();
					sent++;
				end else if (pick < 30) begin
					if ($urandom_range(0, 9) == 0)
						ri = $urandom_range(0, TABLE_ROWS - 1);
					else
						ri = $urandom_range(0, capture_sb.cur_row);
					if ($urandom_range(0, 7) == 0 || capture_sb.row_len[ri] == 0)
						bi = $urandom_range(0, 63);
					else
						bi = $urandom_range(0, int'(capture_sb.row_len[ri]) - 1);
					send_read(ri, bi);
					sent++;
				end else begin
					case (kind)
						0: fresh = ($urandom_range(0, 3) == 0);
						1: fresh = (capture_sb.cur_row < TABLE_ROWS - 1) ||
							($urandom_range(0, 29) == 0);
						default: fresh = ($urandom_range(0, 99) == 0);
					endcase
					// Never append on a row whose start time was never loaded.
					if (capture_sb.row_len[capture_sb.cur_row] == 0 &&
						!capture_sb.start_known[capture_sb.cur_row])
						fresh = 1;
					send_append($urandom_range(0, 1), fresh, next_edge_time());
					sent++;
				end
			end
		end
	endtask

	// Result side: unless quiet, stall a random number of cycles before taking each result.
	initial begin
		int stall;
		result_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 8);
			if (stall != 0) begin
				result_ch.ready = 0;
				repeat (stall) @(negedge clk);
			end
			result_ch.ready = 1;
			do @(posedge clk); while (!result_ch.valid);
			@(negedge clk);
		end
	end

	// Check every accepted result.
	always @(posedge clk) begin
		capture_result_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.accepted     = result_ch.accepted;
			got.level        = result_ch.level;
			got.duration     = result_ch.duration;
			got.row_length   = result_ch.row_length;
			got.row_overflow = result_ch.row_overflow;
			got.row_valid    = result_ch.row_valid;
			capture_sb.check_result(got);
		end
	end

	// Watchdog on cycles in which neither channel moves anything.
	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) ||
			(result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		capture_sb         = new();
		quiet              = 0;
		idle_cycles        = 0;
		arst_n             = 0;
		item_ch.valid      = 0;
		item_ch.op         = OP_APPEND;
		item_ch.pin_level  = 0;
		item_ch.new_row    = 0;
		item_ch.time_stamp = '0;
		item_ch.row_index  = '0;
		item_ch.bit_index  = '0;
		repeat (2) @(negedge clk);
		arst_n = 1;

		run_directed();
		run_random();
		item_ch.valid = 0;

		while (capture_sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (capture_sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: files.f
rtl/ptc_pkg.sv
rtl/ptc_if.sv
rtl/ptc_ram.sv
rtl/ptc_ctrl.sv
rtl/ptc_datapath.sv
rtl/pulse_train_capture_table_core.sv
test/pulse_train_capture_table_core_test.sv
